// ===== src/tnlc_pkg.sv =====
// Shared types and constants of the TDMA node latency collector.
package tnlc_pkg;

    localparam int MAX_NODES  = 32;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int MEM_AW     = NODE_W + 1;
    localparam int CNT_W      = 6;
    localparam int TIME_W     = 32;
    localparam int LAT_W      = 16;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = TIME_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [CNT_W-1:0]  MAX_NODES_C  = CNT_W'(MAX_NODES);
    localparam logic [CNT_W-1:0]  DEF_NODES    = 6'd30;
    localparam int                DEF_SLOT_US  = 3000;
    localparam logic [TIME_W-1:0] DEF_FRAME_US = TIME_W'(30 * DEF_SLOT_US);
    localparam logic [7:0]        DEF_DATA     = 8'hAA;
    localparam logic [5:0]        MIN_PKT_LEN  = 6'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_MARKER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MARKER = 2'd3;

    // result kinds on m_axis_tuser
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic capture;
        logic pkt_write;
        logic swap;
        logic mem_rd;
        logic idx_inc;
        logic load_ack;
        logic load_rpt;
        logic div_start;
        logic align;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic pkt_ok;
        logic aligned;
        logic expired;
        logic n_zero;
        logic idx_last;
        logic out_free;
        logic div_done;
    } t_stat;

endpackage

// ===== src/tnlc_div.sv =====
// Restoring remainder unit, one quotient bit per cycle.
module tnlc_div
    import tnlc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    input  logic [TIME_W-1:0] i_divisor,
    output logic              o_done,
    output logic [TIME_W-1:0] o_rem
);

    logic [TIME_W-1:0]    r_rem;
    logic [TIME_W-1:0]    r_dvd;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [TIME_W:0]      w_shift;
    logic [TIME_W:0]      w_diff;

    assign w_shift = {r_rem, r_dvd[TIME_W-1]};
    assign w_diff  = w_shift - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            if (!w_diff[TIME_W]) begin
                r_rem <= w_diff[TIME_W-1:0];
            end else begin
                r_rem <= w_shift[TIME_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== src/tnlc_ctrl.sv =====
// Sequencer of the collector: packet, tick, report and realignment steps.
module tnlc_ctrl
    import tnlc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_st,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CHECK     = 3'd1;
    localparam logic [2:0] S_ACK       = 3'd2;
    localparam logic [2:0] S_RPT_RD    = 3'd3;
    localparam logic [2:0] S_RPT_EMIT  = 3'd4;
    localparam logic [2:0] S_DIV_START = 3'd5;
    localparam logic [2:0] S_DIV_WAIT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_st.is_tick) begin
                    if (i_st.pkt_ok) begin
                        o_cmd.pkt_write = 1'b1;
                        n_state         = S_ACK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (!i_st.aligned) begin
                    n_state = S_DIV_START;
                end else if (i_st.expired) begin
                    o_cmd.swap = 1'b1;
                    n_state    = i_st.n_zero ? S_DIV_START : S_RPT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ACK: begin
                if (i_st.out_free) begin
                    o_cmd.load_ack = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RPT_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_RPT_EMIT;
            end
            S_RPT_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.load_rpt = 1'b1;
                    if (i_st.idx_last) begin
                        n_state = S_DIV_START;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_RPT_RD;
                    end
                end
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_st.div_done) begin
                    o_cmd.align = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.div_done |-> r_state == S_DIV_WAIT)
        else $error("remainder finished outside the wait step");

endmodule

// ===== src/tnlc_dp.sv =====
// Datapath: configuration, received banks, latency memory, frame timing, result register.
module tnlc_dp
    import tnlc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_st,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TIME_W-1:0]     i_cfg_data,
    output logic                  o_cfg_ready,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_in_user,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_user,
    output logic                  o_out_last
);

    // configuration
    logic [TIME_W-1:0] r_frame_len;
    logic [CNT_W-1:0]  r_node_count;
    logic [7:0]        r_data_marker;

    // captured item
    logic              r_is_tick;
    logic [TIME_W-1:0] r_now;
    logic [5:0]        r_len;
    logic [2:0]        r_pipe;
    logic [7:0]        r_marker;
    logic [7:0]        r_node;
    logic [LAT_W-1:0]  r_lat;

    // frame state
    logic [MAX_NODES-1:0] r_recv [2];
    logic [LAT_W-1:0]     r_lat_mem [2*MAX_NODES];
    logic [LAT_W-1:0]     r_rd_data;
    logic                 r_back;
    logic                 r_rd_bank;
    logic [TIME_W-1:0]    r_frame_start;
    logic                 r_aligned;
    logic [NODE_W-1:0]    r_idx;

    // result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_user;
    logic                  r_out_last;

    logic [CNT_W-1:0]  w_active;
    logic [TIME_W-1:0] w_elapsed;
    logic [TIME_W-1:0] w_rem;
    logic [TIME_W-1:0] w_grid;
    logic [CNT_W-1:0]  w_idx_next;
    logic              w_div_done;
    logic              w_got;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len   <= DEF_FRAME_US;
            r_node_count  <= DEF_NODES;
            r_data_marker <= DEF_DATA;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_LEN:   r_frame_len   <= i_cfg_data;
                REG_NODE_COUNT:  r_node_count  <= i_cfg_data[CNT_W-1:0];
                REG_DATA_MARKER: r_data_marker <= i_cfg_data[7:0];
                // sync requests get an ack like any other marker: nothing stored
                REG_SYNC_MARKER: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_tick <= i_in_user;
            r_now     <= i_in_data[31:0];
            r_len     <= i_in_data[37:32];
            r_pipe    <= i_in_data[40:38];
            r_marker  <= i_in_data[48:41];
            r_node    <= i_in_data[56:49];
            r_lat     <= {i_in_data[64:57], i_in_data[72:65]};
        end
    end

    assign w_active   = (r_node_count > MAX_NODES_C) ? MAX_NODES_C : r_node_count;
    assign w_elapsed  = r_now - r_frame_start;
    assign w_grid     = (r_frame_len == '0) ? r_now : (r_now - w_rem);
    assign w_idx_next = {1'b0, r_idx} + 1'b1;
    assign w_got      = r_recv[r_rd_bank][r_idx];

    tnlc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_now),
        .i_divisor  (r_frame_len),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv[0]     <= '0;
            r_recv[1]     <= '0;
            r_back        <= 1'b0;
            r_rd_bank     <= 1'b0;
            r_frame_start <= '0;
            r_aligned     <= 1'b0;
            r_idx         <= '0;
        end else begin
            if (i_cmd.pkt_write && (r_marker == r_data_marker)) begin
                r_recv[r_back][r_node[NODE_W-1:0]] <= 1'b1;
            end
            if (i_cmd.swap) begin
                r_rd_bank <= r_back;
                r_back    <= ~r_back;
                r_idx     <= '0;
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            // realignment also drops both banks
            if (i_cmd.align) begin
                r_frame_start <= w_grid;
                r_recv[0]     <= '0;
                r_recv[1]     <= '0;
                r_aligned     <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pkt_write && (r_marker == r_data_marker)) begin
            r_lat_mem[{r_back, r_node[NODE_W-1:0]}] <= r_lat;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_lat_mem[{r_rd_bank, r_idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_ack || i_cmd.load_rpt) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // tdata: ack_pipe, ack_time_us, slot_index, slot_received, slot_latency_us
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ack) begin
            r_out_user <= KIND_ACK;
            r_out_last <= 1'b0;
            r_out_data <= {7'd0, 16'd0, 1'b0, 5'd0, r_now, r_pipe};
        end else if (i_cmd.load_rpt) begin
            r_out_user <= KIND_REPORT;
            r_out_last <= (w_idx_next == w_active);
            r_out_data <= {7'd0, (w_got ? r_rd_data : 16'd0), w_got, r_idx,
                           32'd0, 3'd0};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;

    assign o_st.is_tick  = r_is_tick;
    assign o_st.pkt_ok   = (r_len >= MIN_PKT_LEN) && (r_node < {2'b00, w_active});
    assign o_st.aligned  = r_aligned;
    assign o_st.expired  = (w_elapsed >= r_frame_len);
    assign o_st.n_zero   = (w_active == '0);
    assign o_st.idx_last = (w_idx_next == w_active);
    assign o_st.out_free = !r_out_valid || i_out_ready;
    assign o_st.div_done = w_div_done;

    a_align_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.align |=> (r_recv[0] == '0) && (r_recv[1] == '0) && r_aligned)
        else $error("realignment left received flags set");

    a_rpt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_rpt |-> r_aligned && ({1'b0, r_idx} < w_active))
        else $error("report entry outside the active node range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_ack || i_cmd.load_rpt) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");

    a_swap_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.swap |=> (r_back != r_rd_bank) && (r_idx == '0))
        else $error("bank swap did not toggle the back bank");

endmodule

// ===== src/tdma_node_latency_collector_top.sv =====
// A packet item is taken when idle, checked, then acked once the result register is free.
// A tick that does not expire the frame returns to idle after the check; the first tick
// after reset runs the remainder unit and aligns the frame start to the frame-length grid.
// An expiring tick swaps the banks, emits one report entry per active node, then realigns.
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Synchronous active-low reset restores default registers, clears flags, no result pending.
module tdma_node_latency_collector_top
    import tnlc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // now_us, payload_length, rx_pipe, marker_byte, node_byte, latency_high, latency_low
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // ack_pipe, ack_time_us, slot_index, slot_received, slot_latency_us
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [TIME_W-1:0]     i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_st;

    tnlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    tnlc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule
